FILE: src/m61mp_pkg.sv
package m61mp_pkg;

  // field and operand sizes
  localparam int unsigned FIELD_BITS = 61;
  localparam int unsigned HALF_BITS  = 32;
  localparam int unsigned EXP_BITS   = 64;
  localparam int unsigned PROD_BITS  = 2 * HALF_BITS;
  localparam int unsigned WIDE_BITS  = 2 * FIELD_BITS;
  localparam int unsigned STEP_BITS  = 3;

  localparam logic [FIELD_BITS-1:0] FIELD_P   = {FIELD_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0] FIELD_ONE = FIELD_BITS'(1);
  localparam logic [EXP_BITS-1:0]   INV_EXP   = EXP_BITS'(FIELD_P) - EXP_BITS'(2);

  // command codes on the command port
  localparam logic CMD_POWER   = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  // multiplier sequence steps
  localparam logic [STEP_BITS-1:0] STEP_PP_LL = 3'd0;
  localparam logic [STEP_BITS-1:0] STEP_PP_LH = 3'd1;
  localparam logic [STEP_BITS-1:0] STEP_PP_HL = 3'd2;
  localparam logic [STEP_BITS-1:0] STEP_PP_HH = 3'd3;
  localparam logic [STEP_BITS-1:0] STEP_SUM   = 3'd4;
  localparam logic [STEP_BITS-1:0] STEP_FOLD  = 3'd5;
  localparam logic [STEP_BITS-1:0] STEP_LAST  = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_MUL,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_ACC,
    OP_SQR
  } op_t;

  // weight of a partial product
  typedef enum logic [1:0] {
    WT_ONE,
    WT_HALF,
    WT_FULL
  } wt_t;

endpackage

FILE: src/mersenne61_modular_power.sv
// channel   | ports                               | handshake
// ----------+-------------------------------------+---------------------------------
// item in   | command, base_value, exponent       | start high while busy low
// result    | result                              | done high for one cycle
//
// one beat in gives one result beat; busy holds from the cycle after accept
// through done; a zero exponent goes straight from the pick state to done.
// every square and multiply runs on the one 32x32 multiplier as a sequence of steps:
// four partial products, one wide add behind them, then the fold and last steps.
// rst is synchronous and returns the sequencer to idle; the receiver cannot stall.
module mersenne61_modular_power
  import m61mp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  command,
  input  logic [FIELD_BITS-1:0] base_value,
  input  logic [EXP_BITS-1:0]   exponent,
  output logic                  busy,
  output logic                  done,
  output logic [FIELD_BITS-1:0] result
);

  state_t state, state_next;
  op_t    op;

  logic [STEP_BITS-1:0]  step;
  logic [FIELD_BITS-1:0] acc;
  logic [FIELD_BITS-1:0] sq;
  logic [EXP_BITS-1:0]   exp_reg;
  logic [PROD_BITS-1:0]  prod;
  wt_t                   prod_wt;
  logic                  prod_vld;
  logic [WIDE_BITS-1:0]  wide;
  logic [FIELD_BITS:0]   fold1;

  logic                  load_item;
  logic                  mul_last;
  logic                  exp_rest_zero;
  logic [FIELD_BITS-1:0] base_clean;
  logic [FIELD_BITS-1:0] opa;
  logic [HALF_BITS-1:0]  mult_a;
  logic [HALF_BITS-1:0]  mult_b;
  logic [PROD_BITS-1:0]  mult_out;
  logic [WIDE_BITS-1:0]  term;
  logic [FIELD_BITS:0]   fold2;
  logic [FIELD_BITS-1:0] canon;

  assign mul_last      = (step == STEP_LAST);
  assign exp_rest_zero = (exp_reg[EXP_BITS-1:1] == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PICK;
      end
      S_PICK: begin
        if (exp_reg == '0) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_last) begin
          if (op == OP_ACC && exp_rest_zero) state_next = S_DONE;
          else if (op == OP_SQR) state_next = S_PICK;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy      = (state != S_IDLE);
    done      = (state == S_DONE);
    load_item = start && (state == S_IDLE);
  end

  assign result = acc;

  // base of 2^61-1 is the same element as zero
  assign base_clean = (base_value == FIELD_P) ? '0 : base_value;

  // operand halves for the shared multiplier
  assign opa = (op == OP_ACC) ? acc : sq;

  always_comb begin
    mult_a = '0;
    mult_b = '0;
    unique case (step)
      STEP_PP_LL: begin
        mult_a = opa[HALF_BITS-1:0];
        mult_b = sq[HALF_BITS-1:0];
      end
      STEP_PP_LH: begin
        mult_a = opa[HALF_BITS-1:0];
        mult_b = HALF_BITS'(sq[FIELD_BITS-1:HALF_BITS]);
      end
      STEP_PP_HL: begin
        mult_a = HALF_BITS'(opa[FIELD_BITS-1:HALF_BITS]);
        mult_b = sq[HALF_BITS-1:0];
      end
      STEP_PP_HH: begin
        mult_a = HALF_BITS'(opa[FIELD_BITS-1:HALF_BITS]);
        mult_b = HALF_BITS'(sq[FIELD_BITS-1:HALF_BITS]);
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  assign mult_out = PROD_BITS'(mult_a) * PROD_BITS'(mult_b);

  // place the registered partial product at its weight
  always_comb begin
    unique case (prod_wt)
      WT_ONE:  term = WIDE_BITS'(prod);
      WT_HALF: term = WIDE_BITS'(prod) << HALF_BITS;
      WT_FULL: term = WIDE_BITS'(prod) << PROD_BITS;
      default: term = '0;
    endcase
  end

  // second fold and final subtract to the canonical range
  assign fold2 = {1'b0, fold1[FIELD_BITS-1:0]} + (FIELD_BITS+1)'(fold1[FIELD_BITS]);
  assign canon = (fold2 >= (FIELD_BITS+1)'(FIELD_P))
               ? FIELD_BITS'(fold2 - (FIELD_BITS+1)'(FIELD_P))
               : fold2[FIELD_BITS-1:0];

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= STEP_PP_LL;
      prod_vld <= 1'b0;
      op       <= OP_SQR;
    end else begin
      state <= state_next;
      if (state == S_PICK) begin
        step     <= STEP_PP_LL;
        prod_vld <= 1'b0;
        op       <= exp_reg[0] ? OP_ACC : OP_SQR;
      end else if (state == S_MUL) begin
        prod_vld <= (step <= STEP_PP_HH);
        if (mul_last) begin
          step <= STEP_PP_LL;
          op   <= OP_SQR;
        end else begin
          step <= step + STEP_BITS'(1);
        end
      end
    end
  end

  // datapath: partial products, wide sum, folding, write back
  always_ff @(posedge clk) begin
    if (load_item) begin
      acc     <= FIELD_ONE;
      sq      <= base_clean;
      exp_reg <= (command == CMD_INVERSE) ? INV_EXP : exponent;
    end
    if (state == S_MUL) begin
      prod <= mult_out;
      unique case (step)
        STEP_PP_LL: prod_wt <= WT_ONE;
        STEP_PP_HH: prod_wt <= WT_FULL;
        default:    prod_wt <= WT_HALF;
      endcase
      if (step == STEP_PP_LL) wide <= '0;
      else if (prod_vld) wide <= wide + term;
      if (step == STEP_FOLD) begin
        fold1 <= (FIELD_BITS+1)'(wide[FIELD_BITS-1:0])
               + (FIELD_BITS+1)'(wide[WIDE_BITS-1:FIELD_BITS]);
      end
      if (mul_last) begin
        if (op == OP_ACC) begin
          acc <= canon;
        end else begin
          sq      <= canon;
          exp_reg <= exp_reg >> 1;
        end
      end
    end
  end

  // checks
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  a_result_canonical: assert property (@(posedge clk) disable iff (rst)
    done |-> (result != FIELD_P))
    else $error("result not reduced below the modulus");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (step <= STEP_LAST))
    else $error("multiplier step out of range");

endmodule

FILE: tb/testbench.sv
module testbench
  import m61mp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FIELD_BITS-1:0] P_MINUS_1 = FIELD_P - FIELD_BITS'(1);
  localparam logic [FIELD_BITS-1:0] TWO_TO_60 = FIELD_BITS'(1) << 60;
  localparam logic [EXP_BITS-1:0]   EXP_ONES  = {EXP_BITS{1'b1}};

  localparam int NUM_DIRECTED = 23;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_PRINTED  = 30;

  typedef struct packed {
    logic                  cmd;
    logic [FIELD_BITS-1:0] base;
    logic [EXP_BITS-1:0]   power;
    logic                  has_known;
    logic [FIELD_BITS-1:0] known;
  } vector_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  command = CMD_POWER;
  logic [FIELD_BITS-1:0] base_value = '0;
  logic [EXP_BITS-1:0]   exponent = '0;
  logic                  busy;
  logic                  done;
  logic [FIELD_BITS-1:0] result;

  logic [FIELD_BITS-1:0] expected_results[$];
  int mismatch_count = 0;
  int results_checked = 0;
  int power_beats = 0;
  int inverse_beats = 0;

  // fixed table: extremes, zero exponent, base equal to p, inverse of zero
  vector_t directed_vectors [NUM_DIRECTED] = '{
    '{CMD_POWER,   '0,        '0,                  1'b1, FIELD_ONE},
    '{CMD_POWER,   P_MINUS_1, '0,                  1'b1, FIELD_ONE},
    '{CMD_POWER,   FIELD_P,   '0,                  1'b1, FIELD_ONE},
    '{CMD_POWER,   61'd5,     64'd1,               1'b1, 61'd5},
    '{CMD_POWER,   P_MINUS_1, 64'd1,               1'b1, P_MINUS_1},
    '{CMD_POWER,   FIELD_P,   64'd1,               1'b1, '0},
    '{CMD_POWER,   '0,        EXP_ONES,            1'b1, '0},
    '{CMD_POWER,   61'd1,     EXP_ONES,            1'b1, FIELD_ONE},
    '{CMD_POWER,   P_MINUS_1, EXP_ONES,            1'b1, P_MINUS_1},
    '{CMD_POWER,   P_MINUS_1, 64'd2,               1'b1, FIELD_ONE},
    '{CMD_POWER,   61'd2,     64'd60,              1'b1, TWO_TO_60},
    '{CMD_POWER,   61'd2,     64'd61,              1'b1, FIELD_ONE},
    '{CMD_POWER,   61'd3,     64'(P_MINUS_1),      1'b1, FIELD_ONE},
    '{CMD_POWER,   61'd2,     EXP_ONES,            1'b0, '0},
    '{CMD_POWER,   61'h1555_5555_5555_5555, 64'h8000_0000_0000_0000, 1'b0, '0},
    '{CMD_POWER,   61'h0AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{CMD_POWER,   61'h1FFF_FFFF_0000_0001, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
    '{CMD_INVERSE, '0,        EXP_ONES,            1'b1, '0},
    '{CMD_INVERSE, 61'd1,     '0,                  1'b1, FIELD_ONE},
    '{CMD_INVERSE, P_MINUS_1, '0,                  1'b1, P_MINUS_1},
    '{CMD_INVERSE, FIELD_P,   '0,                  1'b1, '0},
    '{CMD_INVERSE, 61'd2,     EXP_ONES,            1'b1, TWO_TO_60},
    '{CMD_INVERSE, 61'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_0123_4567, 1'b0, '0}
  };

  mersenne61_modular_power u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .base_value (base_value),
    .exponent   (exponent),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  always #5 clk = ~clk;

  // field product, reduced to [0, p-1]
  function automatic logic [FIELD_BITS-1:0] field_mul(input logic [FIELD_BITS-1:0] a,
                                                      input logic [FIELD_BITS-1:0] b);
    logic [WIDE_BITS-1:0]  prod;
    logic [FIELD_BITS+1:0] folded;
    prod   = {{FIELD_BITS{1'b0}}, a} * {{FIELD_BITS{1'b0}}, b};
    folded = (FIELD_BITS+2)'(prod[WIDE_BITS-1:FIELD_BITS]) +
             (FIELD_BITS+2)'(prod[FIELD_BITS-1:0]);
    folded = (FIELD_BITS+2)'(folded[FIELD_BITS+1:FIELD_BITS]) +
             (FIELD_BITS+2)'(folded[FIELD_BITS-1:0]);
    if (folded >= (FIELD_BITS+2)'(FIELD_P))
      folded = folded - (FIELD_BITS+2)'(FIELD_P);
    return folded[FIELD_BITS-1:0];
  endfunction

  // expected power or inverse for one command beat
  function automatic logic [FIELD_BITS-1:0] predict_power(input logic cmd,
                                                          input logic [FIELD_BITS-1:0] base,
                                                          input logic [EXP_BITS-1:0] power);
    logic [FIELD_BITS-1:0] acc;
    logic [FIELD_BITS-1:0] sq;
    logic [EXP_BITS-1:0]   e;
    acc = FIELD_ONE;
    sq  = (base == FIELD_P) ? '0 : base;
    e   = (cmd == CMD_INVERSE) ? INV_EXP : power;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i])
        acc = field_mul(acc, sq);
      sq = field_mul(sq, sq);
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // drive one beat and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [FIELD_BITS-1:0] base,
                           input logic [EXP_BITS-1:0] power, input logic has_known,
                           input logic [FIELD_BITS-1:0] known);
    start      <= 1'b1;
    command    <= cmd;
    base_value <= base;
    exponent   <= power;
    do @(posedge clk); while (busy);
    expected_results.push_back(has_known ? known : predict_power(cmd, base, power));
    if (cmd == CMD_INVERSE)
      inverse_beats++;
    else
      power_beats++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result checker: every done beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", result));
      end else begin
        logic [FIELD_BITS-1:0] want;
        want = expected_results.pop_front();
        results_checked++;
        if (result !== want)
          report_mismatch($sformatf("result %h, expected %h", result, want));
      end
    end
  end

  // stimulus
  initial begin
    int sent;
    int burst;
    bit paused;
    logic cmd;
    logic [63:0] rnd;
    logic [FIELD_BITS-1:0] base;
    logic [EXP_BITS-1:0] power;
    int width;

    sent   = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fixed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_beat(directed_vectors[i].cmd, directed_vectors[i].base, directed_vectors[i].power,
                directed_vectors[i].has_known, directed_vectors[i].known);
      idle_cycles($urandom_range(0, 2));
    end
    wait_drained();

    // random bursts with gaps of random length
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        cmd = ($urandom_range(0, 4) == 0) ? CMD_INVERSE : CMD_POWER;
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0: base = '0;
          1: base = FIELD_ONE;
          2: base = P_MINUS_1;
          3: base = FIELD_P;
          4: base = FIELD_BITS'($urandom_range(2, 1000));
          5: base = FIELD_P - FIELD_BITS'($urandom_range(2, 1000));
          default: base = rnd[FIELD_BITS-1:0];
        endcase
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0: power = '0;
          1: power = rnd;
          2: power = EXP_BITS'($urandom_range(1, 16));
          default: begin
            width = $urandom_range(1, 64);
            power = (width == 64) ? rnd : (rnd & ((64'd1 << width) - 64'd1));
          end
        endcase
        send_beat(cmd, base, power, 1'b0, '0);
        sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end else begin
        idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 4));
      end
    end

    // drain and settle
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d power and %0d inverse beats, %0d results checked",
             power_beats, inverse_beats, results_checked);
    $display("table rows: %0d, mismatches: %0d", NUM_DIRECTED, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #(60_000_000);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/m61mp_pkg.sv
src/mersenne61_modular_power.sv
tb/testbench.sv
